[rtl/stm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_pkg: shared types and constants
// Widths, register indexes and the records passed between front, back and divider.
// ----------------------------------------------------------------------------
package stm_pkg;

  localparam int MAX_PROCESSES = 256;
  localparam int WINDOW_DEPTH  = 1024;
  localparam int RING_AW       = 10;
  localparam int PC_W          = 9;
  localparam int WIN_W         = 11;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b1;

  localparam logic [PC_W-1:0]  PC_RESET  = 9'd256;
  localparam logic [WIN_W-1:0] WIN_RESET = 11'd1024;

  localparam logic [1:0] MODE_ONE = 2'd1;
  localparam logic [1:0] MODE_TWO = 2'd2;

  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 384;

  localparam logic [16:0] Q16_ONE = 17'h10000;

  typedef struct packed {
    logic [47:0] square_sum;
    logic [39:0] arrival_sum;
    logic        cpu_busy;
    logic [1:0]  mode_code;
    logic [31:0] decision_ns;
  } tick_rec_t;

  typedef struct packed {
    logic        start;
    logic [48:0] rem0;
    logic [63:0] dend;
    logic [48:0] den;
    logic [6:0]  steps;
  } div_req_t;

endpackage

[rtl/scheduler_tick_metrics.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scheduler_tick_metrics: rolling-window scheduler performance counter
// Collects per-process entries of each tick and emits one metrics snapshot.
//
// Input stream: one request per process entry; tlast marks the closing entry
// of a tick, which also carries the decision fields in tdata and tuser.
// Output stream: one snapshot per closed tick. Config writes (process count,
// window length) are for the user to make only while the block is idle; the
// block does not enforce it. Entries are taken one per cycle unless the reset
// clear or a closing entry facing a full queue holds in_tready low. A closing
// entry is queued (two deep) for the engine: a 48-step ring index, up to three
// 16-step fractions and a 64-step mean on one bit-serial divider, plus ring
// and counter updates. A fraction with a zero denominator (0) or a numerator
// not below it (1.0) skips the divider, which sets the tick rate. After reset
// a pass clears the busy ring, in_tready low. A stalled output holds its
// snapshot; the engine waits behind it, entries flow until the queue fills.
// ----------------------------------------------------------------------------
module scheduler_tick_metrics (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // proc_qlen, arrivals_so_far, decision_ns
  input  logic [stm_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tlast,
  // cpu_busy, mode_code
  input  logic [stm_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // lyapunov_value, lyapunov_drift, rolling_throughput, busy_fraction,
  // mode_two_fraction, mean_decision_ns, total_decision_ns, jobs_completed,
  // jobs_arrived, ticks_seen, zero pad
  output logic [stm_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_we,
  input  logic [stm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [stm_pkg::PC_W-1:0]  pc_r;
  logic [stm_pkg::WIN_W-1:0] win_r;
  logic               push, full, pop, empty, clearing;
  stm_pkg::tick_rec_t push_rec, pop_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= stm_pkg::PC_RESET;
      win_r <= stm_pkg::WIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        stm_pkg::CFG_PROCESS_COUNT: pc_r  <= cfg_data[stm_pkg::PC_W-1:0];
        stm_pkg::CFG_WINDOW_LENGTH: win_r <= cfg_data;
        default: ;
      endcase
    end
  end

  stm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .process_count (pc_r),
    .hold          (clearing),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .in_tuser      (in_tuser),
    .push          (push),
    .push_rec      (push_rec),
    .full          (full)
  );

  stm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (full),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .empty    (empty)
  );

  stm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .window_length (win_r),
    .rec           (pop_rec),
    .empty         (empty),
    .pop           (pop),
    .clearing      (clearing),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata)
  );

endmodule

[rtl/stm_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_fifo: two-entry tick record queue
// Decouples the entry accumulator from the tick engine.
// ----------------------------------------------------------------------------
module stm_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  stm_pkg::tick_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output stm_pkg::tick_rec_t pop_rec,
  output logic              empty
);

  stm_pkg::tick_rec_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign pop_rec = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/stm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_front: per-entry accumulator
// Squares queue lengths, sums squares and arrivals, pushes a record per tick.
// ----------------------------------------------------------------------------
module stm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [stm_pkg::PC_W-1:0]       process_count,
  input  logic                           hold,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [stm_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tlast,
  input  logic [stm_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           push,
  output stm_pkg::tick_rec_t             push_rec,
  input  logic                           full
);

  logic        a_valid_r;
  logic [31:0] prod_r, arr_r, dns_r;
  logic        cnt_r, close_r, busy_r;
  logic [1:0]  mode_r;
  logic [stm_pkg::PC_W-1:0] pos_r;
  logic [47:0] sq_r;
  logic [39:0] arrs_r;

  logic [stm_pkg::PC_W-1:0] pc_eff;
  logic        a_go, take;
  logic [48:0] sq_sum;
  logic [40:0] arr_sum;
  logic [47:0] sq_nxt;
  logic [39:0] arrs_nxt;

  assign pc_eff = (process_count > stm_pkg::PC_W'(stm_pkg::MAX_PROCESSES)) ?
                  stm_pkg::PC_W'(stm_pkg::MAX_PROCESSES) : process_count;
  assign a_go      = a_valid_r && (!close_r || !full);
  assign in_tready = !hold && (!a_valid_r || a_go);
  assign take      = in_tvalid && in_tready;

  always_comb begin
    sq_sum   = {1'b0, sq_r} + {17'b0, prod_r};
    sq_nxt   = !cnt_r ? sq_r : (sq_sum[48] ? '1 : sq_sum[47:0]);
    arr_sum  = {1'b0, arrs_r} + {9'b0, arr_r};
    arrs_nxt = arr_sum[40] ? '1 : arr_sum[39:0];
  end

  assign push     = a_go && close_r;
  assign push_rec = '{square_sum: sq_nxt, arrival_sum: arrs_nxt, cpu_busy: busy_r,
                      mode_code: mode_r, decision_ns: dns_r};

  always_ff @(posedge clk) begin
    if (take) begin
      prod_r  <= {16'b0, in_tdata[15:0]} * {16'b0, in_tdata[15:0]};
      arr_r   <= in_tdata[47:16];
      dns_r   <= in_tdata[79:48];
      cnt_r   <= (pos_r < pc_eff);
      close_r <= in_tlast;
      busy_r  <= in_tuser[0];
      mode_r  <= in_tuser[2:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      pos_r     <= '0;
      sq_r      <= '0;
      arrs_r    <= '0;
    end else begin
      if (take) begin
        a_valid_r <= 1'b1;
        if (in_tlast) begin
          pos_r <= '0;
        end else if (pos_r < stm_pkg::PC_W'(stm_pkg::MAX_PROCESSES)) begin
          pos_r <= pos_r + 1'b1;
        end
      end else if (a_go) begin
        a_valid_r <= 1'b0;
      end
      if (a_go) begin
        if (close_r) begin
          sq_r   <= '0;
          arrs_r <= '0;
        end else begin
          sq_r   <= sq_nxt;
          arrs_r <= arrs_nxt;
        end
      end
    end
  end

endmodule

[rtl/stm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_div: bit-serial restoring divider
// One quotient bit per cycle; start remainder, dividend and step count given.
// ----------------------------------------------------------------------------
module stm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  stm_pkg::div_req_t req,
  output logic              done_r,
  output logic [63:0]       quo_r,
  output logic [48:0]       rem_r
);

  logic [63:0] dend_r;
  logic [48:0] den_r;
  logic [6:0]  cnt_r;
  logic        run_r;
  logic [49:0] r2, diff;
  logic        ge;

  always_comb begin
    r2   = {rem_r, dend_r[63]};
    diff = r2 - {1'b0, den_r};
    ge   = (r2 >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.rem0;
      dend_r <= req.dend;
      den_r  <= req.den;
      cnt_r  <= req.steps;
      quo_r  <= '0;
    end else if (run_r) begin
      rem_r  <= ge ? diff[48:0] : r2[48:0];
      quo_r  <= {quo_r[62:0], ge};
      dend_r <= {dend_r[62:0], 1'b0};
      cnt_r  <= cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == 7'd1) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

[rtl/stm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_back: tick engine
// Counters, busy ring, fractions through the shared divider, snapshot out.
// ----------------------------------------------------------------------------
module stm_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [stm_pkg::WIN_W-1:0]       window_length,
  input  stm_pkg::tick_rec_t              rec,
  input  logic                            empty,
  output logic                            pop,
  output logic                            clearing,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [stm_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_MODW  = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_UPD   = 4'd5;
  localparam logic [3:0] S_OPS   = 4'd6;
  localparam logic [3:0] S_OPW   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam logic [1:0] OP_RING = 2'd0;
  localparam logic [1:0] OP_BUSY = 2'd1;
  localparam logic [1:0] OP_MODE = 2'd2;
  localparam logic [1:0] OP_MEAN = 2'd3;

  logic [3:0]  state_r;
  logic [stm_pkg::WIN_W-1:0] clr_addr_r, ring_sum_r;
  logic [47:0] tick_r, busyt_r, m1_r, m2_r, last_r, v_r;
  logic [63:0] dtot_r;
  logic [48:0] drift_r;
  logic [39:0] arr_r;
  logic        busy_r, rd_r;
  logic [stm_pkg::RING_AW-1:0] idx_r;
  logic [1:0]  op_r;
  logic [16:0] res_thr_r, res_bf_r, res_m2_r;
  logic [31:0] res_mean_r;
  logic        out_valid_r;
  logic [stm_pkg::OUT_DATA_W-1:0] out_data_r;
  logic        ring_mem [stm_pkg::WINDOW_DEPTH];

  logic [stm_pkg::WIN_W-1:0] win_eff;
  logic        ring_we, ring_wd, out_load;
  logic [stm_pkg::RING_AW-1:0] ring_wa;
  logic [48:0] q_num, q_den;
  logic [64:0] dsum;
  stm_pkg::div_req_t req;
  logic        div_done;
  logic [63:0] div_quo;
  logic [48:0] div_rem;

  stm_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .done_r (div_done),
    .quo_r  (div_quo),
    .rem_r  (div_rem)
  );

  always_comb begin
    if (window_length == '0) begin
      win_eff = stm_pkg::WIN_W'(1);
    end else if (window_length > stm_pkg::WIN_W'(stm_pkg::WINDOW_DEPTH)) begin
      win_eff = stm_pkg::WIN_W'(stm_pkg::WINDOW_DEPTH);
    end else begin
      win_eff = window_length;
    end
  end

  always_comb begin
    case (op_r)
      OP_RING: begin
        q_num = {38'b0, ring_sum_r};
        q_den = {38'b0, win_eff};
      end
      OP_BUSY: begin
        q_num = {1'b0, busyt_r};
        q_den = {1'b0, tick_r};
      end
      OP_MODE: begin
        q_num = {1'b0, m2_r};
        q_den = {1'b0, m1_r} + {1'b0, m2_r};
      end
      default: begin
        q_num = '0;
        q_den = {1'b0, tick_r};
      end
    endcase
  end

  always_comb begin
    req = '0;
    if (state_r == S_MOD) begin
      req.start = 1'b1;
      req.dend  = {tick_r, 16'b0};
      req.den   = {38'b0, win_eff};
      req.steps = 7'd48;
    end else if (state_r == S_OPS) begin
      if (op_r == OP_MEAN) begin
        req.start = 1'b1;
        req.dend  = dtot_r;
        req.den   = q_den;
        req.steps = 7'd64;
      end else if (q_den != '0 && q_num < q_den) begin
        req.start = 1'b1;
        req.rem0  = q_num;
        req.den   = q_den;
        req.steps = 7'd16;
      end
    end
  end

  assign clearing   = (state_r == S_CLEAR);
  assign pop        = (state_r == S_IDLE) && !empty;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign dsum       = {1'b0, dtot_r} + {33'b0, rec.decision_ns};

  assign ring_we = clearing || (state_r == S_UPD);
  assign ring_wa = clearing ? clr_addr_r[stm_pkg::RING_AW-1:0] : idx_r;
  assign ring_wd = clearing ? 1'b0 : busy_r;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    rd_r <= ring_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      v_r     <= rec.square_sum;
      arr_r   <= rec.arrival_sum;
      busy_r  <= rec.cpu_busy;
      drift_r <= {1'b0, rec.square_sum} - {1'b0, last_r};
    end
    if (state_r == S_MODW && div_done) begin
      idx_r <= div_rem[stm_pkg::RING_AW-1:0];
    end
    if (state_r == S_OPS && !req.start) begin
      case (op_r)
        OP_RING: res_thr_r <= (q_den == '0) ? '0 : stm_pkg::Q16_ONE;
        OP_BUSY: res_bf_r  <= (q_den == '0) ? '0 : stm_pkg::Q16_ONE;
        default: res_m2_r  <= (q_den == '0) ? '0 : stm_pkg::Q16_ONE;
      endcase
    end
    if (state_r == S_OPW && div_done) begin
      case (op_r)
        OP_RING: res_thr_r  <= {1'b0, div_quo[15:0]};
        OP_BUSY: res_bf_r   <= {1'b0, div_quo[15:0]};
        OP_MODE: res_m2_r   <= {1'b0, div_quo[15:0]};
        default: res_mean_r <= (div_quo[63:32] != '0) ? '1 : div_quo[31:0];
      endcase
    end
    if (out_load) begin
      out_data_r <= {4'b0, tick_r, arr_r, busyt_r, dtot_r, res_mean_r, res_m2_r,
                     res_bf_r, res_thr_r, drift_r, v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      tick_r      <= '0;
      busyt_r     <= '0;
      m1_r        <= '0;
      m2_r        <= '0;
      last_r      <= '0;
      dtot_r      <= '0;
      ring_sum_r  <= '0;
      op_r        <= OP_RING;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == stm_pkg::WIN_W'(stm_pkg::WINDOW_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!empty) begin
            if (!(&tick_r)) tick_r <= tick_r + 1'b1;
            if (rec.mode_code == stm_pkg::MODE_ONE && !(&m1_r)) m1_r <= m1_r + 1'b1;
            if (rec.mode_code == stm_pkg::MODE_TWO && !(&m2_r)) m2_r <= m2_r + 1'b1;
            if (rec.cpu_busy && !(&busyt_r)) busyt_r <= busyt_r + 1'b1;
            dtot_r  <= dsum[64] ? '1 : dsum[63:0];
            last_r  <= rec.square_sum;
            op_r    <= OP_RING;
            state_r <= S_MOD;
          end
        end
        S_MOD: state_r <= S_MODW;
        S_MODW: begin
          if (div_done) state_r <= S_RD;
        end
        S_RD: state_r <= S_UPD;
        S_UPD: begin
          ring_sum_r <= ring_sum_r - {10'b0, rd_r} + {10'b0, busy_r};
          state_r    <= S_OPS;
        end
        S_OPS: begin
          if (req.start) begin
            state_r <= S_OPW;
          end else begin
            op_r <= op_r + 2'd1;
          end
        end
        S_OPW: begin
          if (div_done) begin
            if (op_r == OP_MEAN) begin
              state_r <= S_OUT;
            end else begin
              op_r    <= op_r + 2'd1;
              state_r <= S_OPS;
            end
          end
        end
        S_OUT: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/stm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_checker: port-level checks
// Watches the top-level streams over time; bound to the top level.
// ----------------------------------------------------------------------------
module stm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [stm_pkg::IN_DATA_W-1:0]    in_tdata,
  input logic                             in_tlast,
  input logic [stm_pkg::IN_USER_W-1:0]    in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [stm_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic                             cfg_we,
  input logic [stm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [stm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("snapshot dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("snapshot changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ports active right after reset");

  a_jobs_le_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[291:244] <= out_tdata[379:332])
    else $error("completions exceed ticks");

endmodule

bind scheduler_tick_metrics stm_checker u_stm_checker (.*);

[bench/tick_metrics_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_metrics_checker: snapshot predictor and comparator
// Watches the entry, config and snapshot channels, keeps its own copy of the
// tick counters and busy ring, and compares each snapshot field by field
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module tick_metrics_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [stm_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tlast,
  input  logic [stm_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [stm_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_we,
  input  logic [stm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               fail_count,
  output int                               pending_snapshots,
  output int                               snapshots_seen
);

  typedef struct packed {
    logic [47:0] ticks;
    logic [39:0] arrived;
    logic [47:0] completed;
    logic [63:0] total_ns;
    logic [31:0] mean_ns;
    logic [16:0] mode_two_frac;
    logic [16:0] busy_frac;
    logic [16:0] throughput;
    logic [48:0] drift;
    logic [47:0] lyap;
  } snapshot_t;

  localparam logic [47:0] MAX48 = '1;
  localparam logic [39:0] MAX40 = '1;
  localparam logic [63:0] MAX64 = '1;

  snapshot_t   snapshot_q[$];
  logic [8:0]  proc_cnt;
  logic [10:0] win_len;
  logic [47:0] n_ticks, n_busy, n_mode1, n_mode2, sq_run, sq_prev;
  logic [39:0] arr_run;
  int unsigned entry_pos;
  logic        ring[stm_pkg::WINDOW_DEPTH];
  int unsigned ring_sum;
  logic [63:0] ns_total;

  function automatic logic [16:0] frac_q16(logic [63:0] num, logic [63:0] den);
    logic [127:0] t;
    if (den == 0) return 17'd0;
    if (num >= den) return stm_pkg::Q16_ONE;
    t = {64'd0, num} << 16;
    return 17'(t / den);
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b,
                                          logic [63:0] lim);
    if (a >= lim || b > lim - a) return lim;
    return a + b;
  endfunction

  task automatic report(string what, logic [127:0] got, logic [127:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic take_entry(logic [15:0] qlen, logic [31:0] arr, logic last,
                            logic busy, logic [1:0] mode, logic [31:0] dns);
    int unsigned pc, win, idx;
    snapshot_t s;
    logic [63:0] m;
    pc = (proc_cnt > stm_pkg::MAX_PROCESSES) ? stm_pkg::MAX_PROCESSES : proc_cnt;
    if (entry_pos < pc) sq_run = 48'(add_sat(sq_run, 32'(qlen) * 32'(qlen), MAX48));
    if (entry_pos < stm_pkg::MAX_PROCESSES) entry_pos++;
    arr_run = 40'(add_sat(arr_run, arr, MAX40));
    if (!last) return;
    n_ticks = 48'(add_sat(n_ticks, 1, MAX48));
    if (mode == stm_pkg::MODE_ONE) n_mode1 = 48'(add_sat(n_mode1, 1, MAX48));
    else if (mode == stm_pkg::MODE_TWO) n_mode2 = 48'(add_sat(n_mode2, 1, MAX48));
    s.lyap  = sq_run;
    s.drift = {1'b0, sq_run} - {1'b0, sq_prev};
    sq_prev = sq_run;
    win = (win_len == 0) ? 1 : ((win_len > stm_pkg::WINDOW_DEPTH) ?
                                stm_pkg::WINDOW_DEPTH : win_len);
    idx = int'(n_ticks % win);
    ring_sum = ring_sum - ring[idx] + busy;
    ring[idx] = busy;
    if (busy) n_busy = 48'(add_sat(n_busy, 1, MAX48));
    ns_total = add_sat(ns_total, dns, MAX64);
    s.throughput    = frac_q16(ring_sum, win);
    s.busy_frac     = frac_q16(n_busy, n_ticks);
    s.mode_two_frac = frac_q16(n_mode2, 64'(n_mode1) + 64'(n_mode2));
    m = ns_total / n_ticks;
    s.mean_ns   = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
    s.total_ns  = ns_total;
    s.completed = n_busy;
    s.arrived   = arr_run;
    s.ticks     = n_ticks;
    snapshot_q.push_back(s);
    sq_run = 0;
    arr_run = 0;
    entry_pos = 0;
  endtask

  always @(posedge clk) begin
    snapshot_t g, w;
    if (!rst_n) begin
      proc_cnt = stm_pkg::PC_RESET; win_len = stm_pkg::WIN_RESET;
      n_ticks = 0; n_busy = 0; n_mode1 = 0; n_mode2 = 0;
      sq_run = 0; sq_prev = 0; arr_run = 0; entry_pos = 0;
      ring_sum = 0; ns_total = 0;
      foreach (ring[i]) ring[i] = 1'b0;
      snapshot_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == stm_pkg::CFG_PROCESS_COUNT) proc_cnt = cfg_data[8:0];
        else if (cfg_index == stm_pkg::CFG_WINDOW_LENGTH) win_len = cfg_data[10:0];
      end
      if (in_tvalid && in_tready)
        take_entry(in_tdata[15:0], in_tdata[47:16], in_tlast,
                   in_tuser[0], in_tuser[2:1], in_tdata[79:48]);
      if (out_tvalid && out_tready) begin
        g = out_tdata[$bits(snapshot_t)-1:0];
        snapshots_seen++;
        if (snapshot_q.size() == 0) begin
          report("unexpected snapshot", g.ticks, 0);
        end else begin
          w = snapshot_q.pop_front();
          if (g.lyap != w.lyap) report("lyapunov_value", g.lyap, w.lyap);
          if (g.drift != w.drift) report("lyapunov_drift", g.drift, w.drift);
          if (g.throughput != w.throughput)
            report("rolling_throughput", g.throughput, w.throughput);
          if (g.busy_frac != w.busy_frac) report("busy_fraction", g.busy_frac, w.busy_frac);
          if (g.mode_two_frac != w.mode_two_frac)
            report("mode_two_fraction", g.mode_two_frac, w.mode_two_frac);
          if (g.mean_ns != w.mean_ns) report("mean_decision_ns", g.mean_ns, w.mean_ns);
          if (g.total_ns != w.total_ns) report("total_decision_ns", g.total_ns, w.total_ns);
          if (g.completed != w.completed)
            report("jobs_completed", g.completed, w.completed);
          if (g.arrived != w.arrived) report("jobs_arrived", g.arrived, w.arrived);
          if (g.ticks != w.ticks) report("ticks_seen", g.ticks, w.ticks);
        end
      end
    end
    pending_snapshots = snapshot_q.size();
  end

  initial begin
    fail_count = 0;
    snapshots_seen = 0;
    pending_snapshots = 0;
  end
endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: scheduler tick metrics testbench
// Drives ticks as runs of process entries with random gaps and output stalls,
// sweeps process count and window length between phases, and leaves all
// checking to the snapshot checker and the bound port checks.
// ----------------------------------------------------------------------------
module tb;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid, in_tready, in_tlast;
  logic [stm_pkg::IN_DATA_W-1:0]    in_tdata;
  logic [stm_pkg::IN_USER_W-1:0]    in_tuser;
  logic                             out_tvalid, out_tready;
  logic [stm_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic                             cfg_we;
  logic [stm_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [stm_pkg::CFG_DATA_W-1:0]   cfg_data;
  int                               fail_count, pending_snapshots, snapshots_seen;
  int                               entries_sent;
  bit                               calm;

  scheduler_tick_metrics i_dut (.*);

  tick_metrics_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= calm || ($urandom_range(99) >= 10);
  end

  // valid stays up after an accept; the next request or an idle cycle replaces it
  task automatic send_entry(logic [15:0] qlen, logic [31:0] arr, logic last,
                            logic busy, logic [1:0] mode, logic [31:0] dns);
    while (!calm && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {dns, arr, qlen};
    in_tlast  <= last;
    in_tuser  <= {mode, busy};
    do @(posedge clk); while (!in_tready);
    entries_sent++;
  endtask

  // one tick: n entries, random content, extreme values now and then
  task automatic send_tick(int n);
    logic [15:0] q;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      q = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom);
      a = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom;
      send_entry(q, a, i == n - 1, 1'($urandom), 2'($urandom),
                 ($urandom_range(5) == 0) ? 32'hFFFF_FFFF : $urandom);
    end
  endtask

  task automatic write_reg(logic [stm_pkg::CFG_IDX_W-1:0] idx,
                           logic [stm_pkg::CFG_DATA_W-1:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_snapshots != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int wins[6] = '{1, 0, 3, 1024, 2047, 17};
    int pcs[6]  = '{1, 0, 256, 511, 3, 300};
    int n;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tlast = 1'b0; in_tuser = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0; calm = 1'b0; entries_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, every mode, empty-ish and overlong runs
    send_entry(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 2'd1, 32'hFFFF_FFFF);
    send_entry(16'h0, 32'h0, 1'b1, 1'b0, 2'd2, 32'h0);
    send_entry(16'h8000, 32'h8000_0000, 1'b1, 1'b1, 2'd3, 32'h1);
    send_entry(16'h1, 32'h1, 1'b1, 1'b0, 2'd0, 32'h7FFF_FFFF);
    for (int i = 0; i < 3; i++) send_entry(16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 2'd0, 0);
    send_entry(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 2'd2, 32'hFFFF_FFFF);
    write_reg(stm_pkg::CFG_WINDOW_LENGTH, 11'd2);
    write_reg(stm_pkg::CFG_PROCESS_COUNT, 9'd2);
    send_tick(5);
    send_tick(1);
    send_tick(3);
    send_tick(2);
    // random phases across register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(stm_pkg::CFG_PROCESS_COUNT, 9'(pcs[ph]));
      write_reg(stm_pkg::CFG_WINDOW_LENGTH, 11'(wins[ph]));
      calm = (ph == 3);
      while (entries_sent < 30 + (ph + 1) * 330) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 8);
        send_tick(n);
      end
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_snapshots != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Sent %0d process entries; checked %0d snapshots.", entries_sent,
             snapshots_seen);
    $display("Covered process counts 0..511 and window lengths 0..2047 with stalls.");
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d snapshots outstanding.", pending_snapshots);
    $display("*** FAILED ***");
    $finish;
  end
endmodule

[scheduler_tick_metrics.f]
rtl/stm_pkg.sv
rtl/stm_fifo.sv
rtl/stm_front.sv
rtl/stm_div.sv
rtl/stm_back.sv
rtl/scheduler_tick_metrics.sv
rtl/stm_checker.sv
bench/tick_metrics_checker.sv
bench/tb.sv
